>>> hw/rtl/sgpm_pkg.sv
// ----------------------------------------------------------------------------
// sgpm_pkg: shared types and constants for the stereo gain and peak meter
// Holds the default widths, the gain divisor, controller states and the
// command and status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package sgpm_pkg;

  // default field widths
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int LEVEL_FRAC_BITS_DEF = 24;

  // volume register
  localparam int              VOLUME_BITS  = 8;
  localparam logic [7:0]      VOLUME_RESET = 8'd100;

  // gain is given in percent
  localparam int DIVISOR = 100;

  // coefficient denominators of the level follower
  localparam int ATTACK_DIV  = 20;
  localparam int RELEASE_DIV = 10000;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_EST,
    ST_FIX1,
    ST_FIX2,
    ST_SAT,
    ST_COEF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_MAG,
    ST_FINISH
  } sgpm_state_t;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_GAIN,
    MUL_EST,
    MUL_FIX,
    MUL_LO,
    MUL_HI,
    MUL_MAG
  } sgpm_mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic          ld_in;
    logic          mul_en;
    sgpm_mul_sel_t mul_sel;
    logic          ld_a;
    logic          ld_q0;
    logic          ld_q;
    logic          ld_sat;
    logic          ld_coef;
    logic          acc_round;
    logic          acc_add;
    logic          commit;
  } sgpm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } sgpm_status_t;

endpackage

>>> hw/rtl/sgpm_ctrl.sv
// ----------------------------------------------------------------------------
// sgpm_ctrl: sequencer of the stereo gain and peak meter
// Steps one word at a time through gain, divide by reciprocal, clamp,
// coefficient choice and the three level products on a shared multiplier.
// ----------------------------------------------------------------------------
module sgpm_ctrl
  import sgpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  sgpm_status_t status,
  output sgpm_cmd_t    cmd
);

  sgpm_state_t state;
  sgpm_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_GAIN;
      end
      ST_GAIN:    state_next = ST_EST;
      ST_EST:     state_next = ST_FIX1;
      ST_FIX1:    state_next = ST_FIX2;
      ST_FIX2:    state_next = ST_SAT;
      ST_SAT:     state_next = ST_COEF;
      ST_COEF:    state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_MUL_MAG;
      ST_MUL_MAG: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MUL_GAIN;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      ST_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
      end
      ST_EST: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EST;
        cmd.ld_a    = 1'b1;
      end
      ST_FIX1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FIX;
        cmd.ld_q0   = 1'b1;
      end
      ST_FIX2: begin
        cmd.ld_q = 1'b1;
      end
      ST_SAT: begin
        cmd.ld_sat = 1'b1;
      end
      ST_COEF: begin
        cmd.ld_coef = 1'b1;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
      end
      ST_MUL_HI: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_HI;
        cmd.acc_round = 1'b1;
      end
      ST_MUL_MAG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MAG;
        cmd.acc_add = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd.mul_sel = MUL_GAIN;
      end
    endcase
  end

endmodule

>>> hw/rtl/sgpm_datapath.sv
// ----------------------------------------------------------------------------
// sgpm_datapath: arithmetic and state of the stereo gain and peak meter
// One shared unsigned multiplier, registered product, the volume register,
// both channel levels, channel parity and the output word register.
// ----------------------------------------------------------------------------
module sgpm_datapath
  import sgpm_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [VOLUME_BITS-1:0]                    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]             sample_in,
  input  logic                                      first_in_buffer,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [SAMPLE_BITS-1:0]             sample_out,
  output logic                                      channel,
  output logic [SAMPLE_BITS+LEVEL_FRAC_BITS-1:0]    channel_level,
  output logic                                      saturated,
  input  sgpm_cmd_t                                 cmd,
  output sgpm_status_t                              status
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = LEVEL_FRAC_BITS;
  localparam int LW  = SB + F;
  // gain product |s| * volume, and quotient width
  localparam int AW  = SB + VOLUME_BITS - 1;
  localparam int QW  = SB + 1;
  localparam int S   = AW;
  localparam int OPA = (AW > F) ? AW : F;
  localparam int OPB = (QW > F) ? QW : F;
  localparam int PW  = OPA + OPB;

  localparam logic [63:0]   ONE_F   = 64'd1 << F;
  localparam logic [QW-1:0] RECIP   = QW'((64'd1 << S) / DIVISOR);
  localparam logic [F-1:0]  C_UP    = F'((ONE_F + ATTACK_DIV / 2) / ATTACK_DIV);
  localparam logic [F-1:0]  C_DOWN  = F'((ONE_F + RELEASE_DIV / 2) / RELEASE_DIV);
  localparam logic [F-1:0]  K_UP    = F'(ONE_F - 64'(C_UP));
  localparam logic [F-1:0]  K_DOWN  = F'(ONE_F - 64'(C_DOWN));
  localparam logic [2*F:0]  HALF_F  = (2*F+1)'(ONE_F >> 1);
  localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (SB - 1));

  logic [VOLUME_BITS-1:0] volume;
  logic [SB-1:0]          sample_r;
  logic                   first_r;
  logic [AW-1:0]          a_r;
  logic [QW-1:0]          q0_r;
  logic [QW-1:0]          q_r;
  logic [SB-1:0]          mag_r;
  logic                   ch_r;
  logic [LW-1:0]          level_r;
  logic [F-1:0]           c_r;
  logic [F-1:0]           k_r;
  logic [PW-1:0]          prod;
  logic [LW:0]            acc;
  logic [LW-1:0]          left_level;
  logic [LW-1:0]          right_level;
  logic                   next_is_right;
  logic [SB-1:0]          scaled_r;
  logic                   sat_r;

  logic [SB-1:0]          abs_s;
  logic                   neg;
  logic [OPA-1:0]         op_a;
  logic [OPB-1:0]         op_b;
  logic [AW-1:0]          rem;
  logic [QW-1:0]          q_next;
  logic [QW-1:0]          mag_clamp;
  logic                   sat_next;
  logic                   ch_next;
  logic                   attack;
  logic [2*F:0]           lo_sum;
  logic [LW:0]            level_sum;

  // magnitude of the held sample, the most negative one included
  assign neg   = sample_r[SB-1];
  assign abs_s = neg ? (~sample_r + 1'b1) : sample_r;

  // volume register
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (cfg_we) begin
      volume <= cfg_data;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sample_r <= sample_in;
      first_r  <= first_in_buffer;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_GAIN: begin
        op_a = OPA'(abs_s);
        op_b = OPB'(volume);
      end
      MUL_EST: begin
        op_a = OPA'(prod[AW-1:0]);
        op_b = OPB'(RECIP);
      end
      MUL_FIX: begin
        op_a = OPA'(prod[S +: QW]);
        op_b = OPB'(DIVISOR);
      end
      MUL_LO: begin
        op_a = OPA'(level_r[F-1:0]);
        op_b = OPB'(k_r);
      end
      MUL_HI: begin
        op_a = OPA'(level_r[LW-1:F]);
        op_b = OPB'(k_r);
      end
      MUL_MAG: begin
        op_a = OPA'(mag_r);
        op_b = OPB'(c_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PW'(op_a) * PW'(op_b);
    end
  end

  // reciprocal estimate is at most one low, one compare fixes it
  assign rem    = a_r - prod[AW-1:0];
  assign q_next = (rem >= AW'(DIVISOR)) ? (q0_r + 1'b1) : q0_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_a)  a_r  <= prod[AW-1:0];
    if (cmd.ld_q0) q0_r <= prod[S +: QW];
    if (cmd.ld_q)  q_r  <= q_next;
  end

  // clamp to the sample range, pick channel and its level
  always_comb begin
    sat_next  = 1'b0;
    mag_clamp = q_r;
    if (neg && (q_r > NEG_LIM)) begin
      sat_next  = 1'b1;
      mag_clamp = NEG_LIM;
    end else if (!neg && (q_r > POS_LIM)) begin
      sat_next  = 1'b1;
      mag_clamp = POS_LIM;
    end
  end

  assign ch_next = first_r ? 1'b0 : next_is_right;

  always_ff @(posedge clk) begin
    if (cmd.ld_sat) begin
      mag_r    <= mag_clamp[SB-1:0];
      scaled_r <= neg ? (~mag_clamp[SB-1:0] + 1'b1) : mag_clamp[SB-1:0];
      sat_r    <= sat_next;
      ch_r     <= ch_next;
      level_r  <= ch_next ? right_level : left_level;
    end
  end

  // attack when the magnitude lies above the level
  assign attack = ((LW'(mag_r) << F) > level_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_coef) begin
      c_r <= attack ? C_UP : C_DOWN;
      k_r <= attack ? K_UP : K_DOWN;
    end
  end

  // level accumulation: rounded low part, high part, then attack term
  assign lo_sum    = {1'b0, prod[2*F-1:0]} + HALF_F;
  assign level_sum = acc + (LW+1)'(prod[LW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.acc_round) begin
      acc <= (LW+1)'(lo_sum[2*F:F]);
    end else if (cmd.acc_add) begin
      acc <= level_sum;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_level    <= '0;
      right_level   <= '0;
      next_is_right <= 1'b0;
    end else if (cmd.commit) begin
      next_is_right <= !ch_r;
      if (ch_r) begin
        right_level <= level_sum[LW-1:0];
      end else begin
        left_level  <= level_sum[LW-1:0];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out    <= $signed(scaled_r);
      channel       <= ch_r;
      channel_level <= level_sum[LW-1:0];
      saturated     <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

>>> hw/rtl/stereo_gain_peak_meter.sv
// Each sample steps through gain, estimate, fix, clamp, coefficient, low,
// high and magnitude steps, six products on one shared multiplier, then a
// finish step that registers the result word and is the only one a waiting
// result stalls. The next sample is taken after that, while a result waits.
// Reset (rst, synchronous): volume 100, both levels zero, next sample left.
// ----------------------------------------------------------------------------
// stereo_gain_peak_meter: stereo volume stage with per-channel peak meters
// Scales each interleaved sample by volume/100 with clamping and follows
// each channel's magnitude with an attack/release exponential average.
// ----------------------------------------------------------------------------
module stereo_gain_peak_meter
  import sgpm_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [VOLUME_BITS-1:0]                 cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  logic                                   first_in_buffer,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          sample_out,
  output logic                                   channel,
  output logic [SAMPLE_BITS+LEVEL_FRAC_BITS-1:0] channel_level,
  output logic                                   saturated
);

  sgpm_cmd_t    cmd;
  sgpm_status_t status;

  // sequencer
  sgpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  sgpm_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .sample_in       (sample_in),
    .first_in_buffer (first_in_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .channel         (channel),
    .channel_level   (channel_level),
    .saturated       (saturated),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
